@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl of the probed hash table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked during reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lpht_pkg.sv @@
// types and constants of the probed hash table
`default_nettype none

package lpht_pkg;

    localparam int KEY_W   = 32;
    localparam int COUNT_W = 32;
    localparam int SLOT_W  = 12;

    // operation codes
    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_INSERT = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_W-1:0] COUNT_NEW = COUNT_W'(1);

    // command beat
    typedef struct packed {
        logic             func;
        logic [KEY_W-1:0] key;
    } cmd_t;

    // result beat
    typedef struct packed {
        logic              hit;
        logic [KEY_W-1:0]  found_key;
        logic [SLOT_W-1:0] slot;
        logic              replaced;
    } result_t;

    // one table entry as stored in memory
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [KEY_W-1:0]   key;
    } entry_t;

endpackage

`default_nettype wire

@@ rtl/lpht_ram.sv @@
// generic single-write, single-read ram with registered read data
`default_nettype none

module lpht_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2052,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/lfu_probed_hash_table.sv @@
// Hash table of BUCKETS + PROBE_DEPTH - 1 slots with linear probing and
// least-used replacement. A command beat is taken when start is high and
// busy is low; its result is shown for one cycle with done high and the
// receiver must take it then. After reset the block clears its table, one
// slot a cycle, with busy high. A key of zero gets an all-zero result with
// no probe. Otherwise each probed slot is a memory read, then an evaluate
// and write-back step, and busy stays high until the result; when BUCKETS
// is not a power of two the home slot first comes from a reciprocal
// multiply and a remainder step. The single entry memory port sets this
// sequence.
`default_nettype none

module lfu_probed_hash_table #(
    parameter int BUCKETS     = 2048,
    parameter int PROBE_DEPTH = 5
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire lpht_pkg::cmd_t   cmd,
    output logic                  done,
    output lpht_pkg::result_t     result
);

`include "assert_macros.svh"

    localparam int TABLE_SLOTS = BUCKETS + PROBE_DEPTH - 1;
    localparam int AW     = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int PW     = (PROBE_DEPTH > 1) ? $clog2(PROBE_DEPTH) : 1;
    localparam int XW     = (AW > lpht_pkg::SLOT_W) ? AW : lpht_pkg::SLOT_W;
    localparam int MW     = 2 * lpht_pkg::KEY_W;
    localparam int RECIP_SH = $clog2(BUCKETS);
    localparam int ENTRY_W = $bits(lpht_pkg::entry_t);
    localparam bit POW2   = ((BUCKETS & (BUCKETS - 1)) == 0);

    localparam logic [AW-1:0]   LAST_SLOT  = AW'(TABLE_SLOTS - 1);
    localparam logic [PW-1:0]   LAST_PROBE = PW'(PROBE_DEPTH - 1);
    localparam logic [lpht_pkg::KEY_W-1:0] HOME_MASK = lpht_pkg::KEY_W'(BUCKETS - 1);
    localparam logic [lpht_pkg::KEY_W-1:0] BUCKETS_K = lpht_pkg::KEY_W'(BUCKETS);

    // reciprocal of BUCKETS, rounded up, exact for every 32-bit key
    localparam logic [MW-1:0] RECIP_NUM = MW'(1) << (lpht_pkg::KEY_W + RECIP_SH);
    localparam logic [lpht_pkg::KEY_W:0] RECIP =
        (lpht_pkg::KEY_W + 1)'((RECIP_NUM + MW'(BUCKETS - 1)) / MW'(BUCKETS));

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_REM,
        S_READ,
        S_EVAL
    } state_t;

    state_t                        state_reg,  state_next;
    logic [AW-1:0]                 clr_reg,    clr_next;
    logic                          func_reg,   func_next;
    logic [lpht_pkg::KEY_W-1:0]    key_reg,    key_next;
    logic [lpht_pkg::KEY_W-1:0]    quot_reg,   quot_next;
    logic [AW-1:0]                 home_reg,   home_next;
    logic [PW-1:0]                 probe_reg,  probe_next;
    logic [lpht_pkg::COUNT_W-1:0]  least_reg,  least_next;
    logic [AW-1:0]                 victim_reg, victim_next;
    logic                          done_reg,   done_next;
    lpht_pkg::result_t             result_reg, result_next;

    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    lpht_pkg::entry_t              wr_entry;
    lpht_pkg::entry_t              rd_entry;
    logic [AW-1:0]                 rd_addr;
    logic [MW:0]                   quot_wide;
    logic [lpht_pkg::KEY_W-1:0]    quot_cur;
    logic [lpht_pkg::KEY_W-1:0]    rem_full;
    logic [lpht_pkg::COUNT_W-1:0]  least_cur;
    logic [AW-1:0]                 victim_cur;
    logic                          last_probe;

    // slot index to result field width
    function automatic logic [lpht_pkg::SLOT_W-1:0] slot_of(input logic [AW-1:0] idx);
        logic [XW-1:0] wide;
        wide = XW'(idx);
        return wide[lpht_pkg::SLOT_W-1:0];
    endfunction

    // entry memory: key and use count side by side
    lpht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_entry),
        .raddr (rd_addr),
        .rdata (rd_entry)
    );

    // probe address and per-slot helpers
    assign rd_addr    = home_reg + AW'(probe_reg);
    assign last_probe = (probe_reg == LAST_PROBE);

    // home slot for other bucket counts: quotient by reciprocal, then remainder
    assign quot_wide = (MW + 1)'(key_reg) * (MW + 1)'(RECIP);
    assign quot_cur  = lpht_pkg::KEY_W'(quot_wide >> (lpht_pkg::KEY_W + RECIP_SH));
    assign rem_full  = key_reg - quot_reg * BUCKETS_K;

    // running least count over the probe window, first one wins on ties
    always_comb
    begin
        if (probe_reg == '0 || rd_entry.count < least_reg)
        begin
            least_cur  = rd_entry.count;
            victim_cur = rd_addr;
        end
        else
        begin
            least_cur  = least_reg;
            victim_cur = victim_reg;
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        func_next   = func_reg;
        key_next    = key_reg;
        quot_next   = quot_reg;
        home_next   = home_reg;
        probe_next  = probe_reg;
        least_next  = least_reg;
        victim_next = victim_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        ram_we      = 1'b0;
        ram_waddr   = rd_addr;
        wr_entry    = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                if (clr_reg == LAST_SLOT)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + AW'(1);
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    func_next  = cmd.func;
                    key_next   = cmd.key;
                    probe_next = '0;
                    if (cmd.key == '0)
                    begin
                        done_next   = 1'b1;
                        result_next = '0;
                    end
                    else if (POW2)
                    begin
                        home_next  = AW'(cmd.key & HOME_MASK);
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_MOD;
                    end
                end
            end
            S_MOD:
            begin
                // quotient of key by bucket count
                quot_next  = quot_cur;
                state_next = S_REM;
            end
            S_REM:
            begin
                // remainder is below BUCKETS, so it fits a slot index
                home_next  = AW'(rem_full);
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                least_next  = least_cur;
                victim_next = victim_cur;
                if (func_reg == lpht_pkg::FUNC_LOOKUP)
                begin
                    if (rd_entry.key == key_reg)
                    begin
                        // hit: bump the use count, saturating
                        ram_we         = 1'b1;
                        wr_entry.key   = key_reg;
                        wr_entry.count = (rd_entry.count == lpht_pkg::COUNT_MAX) ?
                                         rd_entry.count :
                                         rd_entry.count + lpht_pkg::COUNT_NEW;
                        done_next             = 1'b1;
                        result_next.hit       = 1'b1;
                        result_next.found_key = key_reg;
                        result_next.slot      = slot_of(rd_addr);
                        result_next.replaced  = 1'b0;
                        state_next            = S_IDLE;
                    end
                    else if (last_probe)
                    begin
                        done_next   = 1'b1;
                        result_next = '0;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        probe_next = probe_reg + PW'(1);
                        state_next = S_READ;
                    end
                end
                else
                begin
                    wr_entry.key   = key_reg;
                    wr_entry.count = lpht_pkg::COUNT_NEW;
                    if (rd_entry.key == '0)
                    begin
                        // empty slot in the window
                        ram_we                = 1'b1;
                        done_next             = 1'b1;
                        result_next.hit       = 1'b0;
                        result_next.found_key = '0;
                        result_next.slot      = slot_of(rd_addr);
                        result_next.replaced  = 1'b0;
                        state_next            = S_IDLE;
                    end
                    else if (last_probe)
                    begin
                        // window full: evict the least-used slot
                        ram_we                = 1'b1;
                        ram_waddr             = victim_cur;
                        done_next             = 1'b1;
                        result_next.hit       = 1'b0;
                        result_next.found_key = '0;
                        result_next.slot      = slot_of(victim_cur);
                        result_next.replaced  = 1'b1;
                        state_next            = S_IDLE;
                    end
                    else
                    begin
                        probe_next = probe_reg + PW'(1);
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            func_reg   <= 1'b0;
            key_reg    <= '0;
            quot_reg   <= '0;
            home_reg   <= '0;
            probe_reg  <= '0;
            least_reg  <= '0;
            victim_reg <= '0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            func_reg   <= func_next;
            key_reg    <= key_next;
            quot_reg   <= quot_next;
            home_reg   <= home_next;
            probe_reg  <= probe_next;
            least_reg  <= least_next;
            victim_reg <= victim_next;
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // checks
    `ASSERT_IMP(a_hit_key, clk, rst_n, done_reg && result_reg.hit,
        result_reg.found_key == key_reg && key_reg != '0, "hit reports wrong key")
    `ASSERT_IMP(a_hit_no_evict, clk, rst_n, done_reg,
        !(result_reg.hit && result_reg.replaced), "hit and eviction in one result")
    `ASSERT_IMP(a_write_owner, clk, rst_n, ram_we,
        state_reg == S_CLEAR || state_reg == S_EVAL, "memory write outside clear or update")
    `ASSERT_IMP(a_probe_range, clk, rst_n, state_reg == S_READ,
        rd_addr <= LAST_SLOT, "probe address beyond table")
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy && cmd.key != '0,
        busy, "accepted key did not start a probe")

endmodule

`default_nettype wire
